// File: rtl/core/assert_macros.svh
// Assertion helpers; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define MPD_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define MPD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define MPD_ASSERT(label, expr, msg)

`define MPD_ASSERT_IMPLY(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/mpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

    localparam int MODE_W  = 2;
    localparam int TERM_FW = 3;
    localparam int POS_W   = 32;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // one compare slot entering the lowering datapath
    typedef struct packed {
        logic valid;
        logic pair_valid;   // pair already holds a minimum
    } lower_req_t;

    // write-back request toward the pair memory
    typedef struct packed {
        logic             pending;
        logic             wr_en;
        logic [POS_W-1:0] gap;
    } lower_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/min_pairwise_term_distance_top.sv
// Minimum pairwise term distance tracker.
// Request channel (req_valid / req_stall): mode, term, position, other_term.
//   mode clear drops every seen mark, record stores an occurrence of term at
//   position and lowers the minimum of each pair it forms with a seen term,
//   read returns the minimum of pair (term, other_term).
// Response channel (rsp_valid / rsp_stall): distance and found, exactly one
//   response per request, in request order; zero for anything but a read.
// Timing: one request is in work at a time. A record runs a term sweep:
//   one position memory read and one pair memory read-modify-write per
//   term, plus a drain of the compare pipe, shorter when the last terms of
//   the sweep need no compare. A read issues one pair memory read; a
//   clear, an unused mode or an ignored record goes straight to the response.
// Response sits in an output register; a new request is taken while it
//   waits. If the receiver stalls, the finished response of the following
//   request is held inside until the output register frees up.
// Reset: asynchronous, active low. All seen marks clear; position and pair
//   memories are not cleared and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module min_pairwise_term_distance_top
    import mpd_pkg::*;
#(
    parameter int TERM_COUNT = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [MODE_W-1:0]  mode,
    input  wire logic [TERM_FW-1:0] term,
    input  wire logic [POS_W-1:0]   position,
    input  wire logic [TERM_FW-1:0] other_term,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic [POS_W-1:0]        distance,
    output logic                    found
);

    localparam int TERM_W     = (TERM_COUNT > 1) ? $clog2(TERM_COUNT) : 1;
    localparam int PAIR_AW    = 2 * TERM_W;
    localparam int PAIR_DEPTH = 1 << PAIR_AW;
    localparam logic [TERM_W-1:0] LAST_IDX = TERM_W'(TERM_COUNT - 1);

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOP   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_RDISS  = 3'd3;
    localparam logic [2:0] ST_RDDATA = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    // storage: last position per term, canonical (low, high) pair minimum.
    // Pair valid is derived: a pair of distinct terms holds a minimum exactly
    // when both have been seen since the last clear.
    logic [POS_W-1:0] pos_mem  [TERM_COUNT];
    logic [POS_W-1:0] pair_mem [PAIR_DEPTH];
    logic [POS_W-1:0] pos_rd_reg;
    logic [POS_W-1:0] pair_rd_reg;

    logic [2:0]            state_reg;
    logic [TERM_COUNT-1:0] seen_reg;
    logic [TERM_W-1:0]     cnt_reg;

    logic [MODE_W-1:0] req_mode_reg;
    logic [TERM_W-1:0] req_t_reg;
    logic [TERM_W-1:0] req_u_reg;
    logic              req_t_ok_reg;
    logic              req_u_ok_reg;
    logic [POS_W-1:0]  req_pos_reg;
    logic              t_was_seen_reg;

    logic              s1v_reg;
    logic [TERM_W-1:0] s1_idx_reg;
    logic [PAIR_AW-1:0] s1_addr_reg;
    logic [PAIR_AW-1:0] s2_addr_reg;

    logic [POS_W-1:0] res_dist_reg;
    logic             res_found_reg;
    logic             rsp_valid_reg;
    logic [POS_W-1:0] dist_out_reg;
    logic             found_out_reg;

    logic               accept;
    logic               in_t_ok;
    logic               in_u_ok;
    logic [TERM_W-1:0]  in_t;
    logic [TERM_W-1:0]  in_u;
    logic               out_free;
    logic [TERM_W-1:0]  pa_lo;
    logic [TERM_W-1:0]  pa_hi;
    logic [PAIR_AW-1:0] pair_raddr;
    logic               slot_live;
    logic               rd_found;
    lower_req_t         lreq;
    lower_wr_t          lwr;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign in_t_ok   = 32'(term) < 32'(TERM_COUNT);
    assign in_u_ok   = 32'(other_term) < 32'(TERM_COUNT);
    assign in_t      = TERM_W'(term);
    assign in_u      = TERM_W'(other_term);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // pair address: sweep partner during a record, (term, other_term) on a read
    always_comb
    begin
        if (state_reg == ST_LOOP)
        begin
            pa_lo = (cnt_reg < req_t_reg) ? cnt_reg : req_t_reg;
            pa_hi = (cnt_reg < req_t_reg) ? req_t_reg : cnt_reg;
        end
        else
        begin
            pa_lo = (req_u_reg < req_t_reg) ? req_u_reg : req_t_reg;
            pa_hi = (req_u_reg < req_t_reg) ? req_t_reg : req_u_reg;
        end
        pair_raddr = {pa_lo, pa_hi};
    end

    // a sweep slot compares only against other terms already seen
    assign slot_live = (state_reg == ST_LOOP) && (cnt_reg != req_t_reg) && seen_reg[cnt_reg];

    assign rd_found = req_t_ok_reg && req_u_ok_reg && (req_t_reg != req_u_reg)
                      && seen_reg[req_t_reg] && seen_reg[req_u_reg];

    // position memory: written on record acceptance, read by the sweep
    always_ff @(posedge clk)
    begin
        if (accept && (mode == MODE_RECORD) && in_t_ok)
        begin
            pos_mem[in_t] <= position;
        end
        pos_rd_reg <= pos_mem[cnt_reg];
    end

    // pair memory: read-modify-write, write address piped via s1/s2_addr_reg;
    // addresses within one sweep are all distinct so no forwarding is needed
    always_ff @(posedge clk)
    begin
        if (lwr.wr_en)
        begin
            pair_mem[s2_addr_reg] <= lwr.gap;
        end
        pair_rd_reg <= pair_mem[pair_raddr];
    end

    always_comb
    begin
        lreq.valid      = s1v_reg;
        lreq.pair_valid = t_was_seen_reg;
    end

    mpd_lower_unit u_lower (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (lreq),
        .other_pos (pos_rd_reg),
        .new_pos   (req_pos_reg),
        .old_min   (pair_rd_reg),
        .wr        (lwr)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            cnt_reg       <= '0;
            s1v_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1v_reg <= slot_live;
            // load a finished response, or retire the one just taken
            if ((state_reg == ST_FIN) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        if (mode == MODE_CLEAR)
                        begin
                            seen_reg  <= '0;
                            state_reg <= ST_FIN;
                        end
                        else if (mode == MODE_RECORD && in_t_ok)
                        begin
                            seen_reg[in_t] <= 1'b1;
                            state_reg      <= ST_LOOP;
                        end
                        else if (mode == MODE_READ)
                        begin
                            state_reg <= ST_RDISS;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_LOOP:
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= TERM_W'(cnt_reg + 1'b1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!s1v_reg && !lwr.pending)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_RDISS:
                begin
                    state_reg <= ST_RDDATA;
                end
                ST_RDDATA:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_mode_reg   <= mode;
            req_t_reg      <= in_t;
            req_u_reg      <= in_u;
            req_t_ok_reg   <= in_t_ok;
            req_u_ok_reg   <= in_u_ok;
            req_pos_reg    <= position;
            t_was_seen_reg <= in_t_ok && seen_reg[in_t];
            res_dist_reg   <= '0;
            res_found_reg  <= 1'b0;
        end
        if (state_reg == ST_RDDATA)
        begin
            res_dist_reg  <= rd_found ? pair_rd_reg : '0;
            res_found_reg <= rd_found;
        end
        s1_idx_reg  <= cnt_reg;
        s1_addr_reg <= pair_raddr;
        s2_addr_reg <= s1_addr_reg;
        if ((state_reg == ST_FIN) && out_free)
        begin
            dist_out_reg  <= res_dist_reg;
            found_out_reg <= res_found_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign distance  = dist_out_reg;
    assign found     = found_out_reg;

    `MPD_ASSERT_IMPLY(a_pipe_addr_distinct, s1v_reg && lwr.pending,
        s1_addr_reg != s2_addr_reg, "pair read and write-back hit the same entry")
    `MPD_ASSERT_IMPLY(a_wr_in_sweep, lwr.wr_en,
        (state_reg == ST_LOOP) || (state_reg == ST_DRAIN), "pair write outside a record sweep")
    `MPD_ASSERT_IMPLY(a_loop_is_record, state_reg == ST_LOOP,
        (req_mode_reg == MODE_RECORD) && req_t_ok_reg, "sweep running without a valid record")
    `MPD_ASSERT_IMPLY(a_slot_seen, s1v_reg,
        seen_reg[s1_idx_reg] && (s1_idx_reg != req_t_reg), "compare slot on an unseen or own term")

endmodule

`default_nettype wire

// File: rtl/core/mpd_lower_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module mpd_lower_unit
    import mpd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lower_req_t       req,
    input  wire logic [POS_W-1:0] other_pos,
    input  wire logic [POS_W-1:0] new_pos,
    input  wire logic [POS_W-1:0] old_min,
    output lower_wr_t             wr
);

    logic             v_reg;
    logic             pv_reg;
    logic [POS_W-1:0] dist_reg;
    logic [POS_W-1:0] min_reg;
    logic [POS_W-1:0] dist_next;

    // exact unsigned absolute difference
    always_comb
    begin
        if (other_pos > new_pos)
        begin
            dist_next = other_pos - new_pos;
        end
        else
        begin
            dist_next = new_pos - other_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pv_reg   <= req.pair_valid;
        dist_reg <= dist_next;
        min_reg  <= old_min;
    end

    always_comb
    begin
        wr.pending = v_reg;
        wr.wr_en   = v_reg && (!pv_reg || (dist_reg < min_reg));
        wr.gap     = dist_reg;
    end

endmodule

`default_nettype wire

// File: bench/tb_min_pairwise_term_distance_top.sv
`timescale 1ns / 1ps

module tb_min_pairwise_term_distance_top;
    import mpd_pkg::*;

    localparam int TERMS = 8;
    // mode code the block leaves unused: no state change, zero response
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1900;
    localparam int HOLD_CYCLES = 300;

    // response as seen on the output ports
    typedef struct packed {
        logic [POS_W-1:0] distance;
        logic             found;
    } minimum_rsp_t;

    // directed row; when known is set the response is typed in here,
    // otherwise the predictor supplies it
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [TERM_FW-1:0] term;
        logic [POS_W-1:0]   position;
        logic [TERM_FW-1:0] other_term;
        logic               known;
        logic [POS_W-1:0]   distance;
        logic               found;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [MODE_W-1:0]  mode = MODE_CLEAR;
    logic [TERM_FW-1:0] term = '0;
    logic [POS_W-1:0]   position = '0;
    logic [TERM_FW-1:0] other_term = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [POS_W-1:0]   distance;
    logic               found;

    // predictor state: latest position per term, pair minima with marks
    logic [POS_W-1:0] latest_pos [TERMS];
    logic             term_active [TERMS];
    logic [POS_W-1:0] pair_gap [TERMS*TERMS];
    logic             pair_known [TERMS*TERMS];

    minimum_rsp_t awaited_minima[$];
    int mismatches = 0;

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int stall_pct = 0;
    // long receiver hold-off: main thread bumps hold_asked, receiver serves it
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    min_pairwise_term_distance_top #(
        .TERM_COUNT(TERMS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .mode       (mode),
        .term       (term),
        .position   (position),
        .other_term (other_term),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .distance   (distance),
        .found      (found)
    );

    always #4 clk = ~clk;

    // hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void clear_tracker();
        for (int i = 0; i < TERMS; i++)
        begin
            term_active[i] = 1'b0;
        end
        for (int k = 0; k < TERMS*TERMS; k++)
        begin
            pair_known[k] = 1'b0;
        end
    endfunction

    // Applies one request to the tracker copy and returns the response it
    // should produce. Record: latest position updated first, then each other
    // seen term is compared and the symmetric pair minimum lowered.
    function automatic minimum_rsp_t predict_minimum(logic [MODE_W-1:0] m,
                                                     logic [TERM_FW-1:0] t,
                                                     logic [POS_W-1:0] p,
                                                     logic [TERM_FW-1:0] u);
        minimum_rsp_t r;
        logic [POS_W-1:0] gap;
        int ab;
        int ba;
        r = '0;
        case (m)
            MODE_CLEAR:
            begin
                clear_tracker();
            end
            MODE_RECORD:
            begin
                latest_pos[t] = p;
                term_active[t] = 1'b1;
                for (int i = 0; i < TERMS; i++)
                begin
                    if (i != int'(t) && term_active[i])
                    begin
                        gap = (latest_pos[i] > p) ? latest_pos[i] - p : p - latest_pos[i];
                        ab = int'(t) * TERMS + i;
                        ba = i * TERMS + int'(t);
                        if (!pair_known[ab] || gap < pair_gap[ab])
                        begin
                            pair_gap[ab] = gap;
                            pair_gap[ba] = gap;
                            pair_known[ab] = 1'b1;
                            pair_known[ba] = 1'b1;
                        end
                    end
                end
            end
            MODE_READ:
            begin
                ab = int'(t) * TERMS + int'(u);
                if (pair_known[ab])
                begin
                    r.distance = pair_gap[ab];
                    r.found = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [POS_W-1:0] got,
                                   logic [POS_W-1:0] want);
        $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offers one request at the falling edge, holds it until accepted, then
    // queues the response. Override is used by directed rows with a typed
    // answer; the predictor still runs so its state stays in step.
    task automatic send_request(logic [MODE_W-1:0] m, logic [TERM_FW-1:0] t,
                                logic [POS_W-1:0] p, logic [TERM_FW-1:0] u,
                                logic known, minimum_rsp_t typed);
        minimum_rsp_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid  <= 1'b1;
        mode       <= m;
        term       <= t;
        position   <= p;
        other_term <= u;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        predicted = predict_minimum(m, t, p, u);
        awaited_minima.insert(awaited_minima.size(), known ? typed : predicted);
    endtask

    task automatic send_random(logic [MODE_W-1:0] m, logic [TERM_FW-1:0] t,
                               logic [POS_W-1:0] p, logic [TERM_FW-1:0] u);
        send_request(m, t, p, u, 1'b0, '0);
    endtask

    task automatic send_read_pair();
        logic [TERM_FW-1:0] a;
        a = TERM_FW'($urandom_range(TERMS - 1));
        // diagonal now and then, otherwise any pair
        send_random(MODE_READ, a, $urandom,
                    ($urandom_range(9) == 0) ? a : TERM_FW'($urandom_range(TERMS - 1)));
    endtask

    // One document: usually opened by a clear, then occurrences in non-descending
    // position order as the sender's merge would produce, reads mixed in.
    task automatic send_document(inout int sent);
        logic [POS_W:0] next_pos;
        logic [POS_W-1:0] pos;
        int len;
        int step_kind;
        if ($urandom_range(9) != 0)
        begin
            send_random(MODE_CLEAR, TERM_FW'($urandom), $urandom, TERM_FW'($urandom));
            sent++;
        end
        pos = ($urandom_range(3) == 0) ? $urandom_range(64) : $urandom;
        len = $urandom_range(4, 30);
        for (int i = 0; i < len; i++)
        begin
            send_random(MODE_RECORD, TERM_FW'($urandom_range(TERMS - 1)), pos,
                        TERM_FW'($urandom));
            sent++;
            step_kind = $urandom_range(9);
            if (step_kind == 0)
                next_pos = {1'b0, pos};
            else if (step_kind < 8)
                next_pos = {1'b0, pos} + $urandom_range(1, 40);
            else
                next_pos = {1'b0, pos} + {1'b0, $urandom};
            pos = next_pos[POS_W] ? '1 : next_pos[POS_W-1:0];
            if ($urandom_range(3) == 0)
            begin
                send_read_pair();
                sent++;
            end
        end
        repeat ($urandom_range(1, 4))
        begin
            send_read_pair();
            sent++;
        end
    endtask

    // Anything the fields allow, unused mode and out-of-order positions too.
    task automatic send_noise(inout int sent);
        send_random(MODE_W'($urandom), TERM_FW'($urandom), $urandom, TERM_FW'($urandom));
        sent++;
    endtask

    task automatic drain_responses();
        while (awaited_minima.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver: random stall at the falling edge, or a long hold-off when
    // the main thread asks for one; the hold is counted here.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_asked != hold_served)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_served <= hold_served + 1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Response checker: every accepted response against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        minimum_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_minima.size() == 0)
            begin
                report_mismatch("unexpected response", distance, '0);
            end
            else
            begin
                want = awaited_minima.pop_front();
                if (distance !== want.distance)
                    report_mismatch("distance", distance, want.distance);
                if (found !== want.found)
                    report_mismatch("found", POS_W'(found), POS_W'(want.found));
            end
        end
    end

    // Directed part: extremes of the position, every mode, diagonal read,
    // zero distance, repeated term, clear dropping all marks, unused mode.
    directed_row_t directed_rows [25] = '{
        '{MODE_READ,   3'd0, 32'h0,        3'd1, 1'b1, 32'h0,        1'b0},
        '{MODE_READ,   3'd7, 32'h0,        3'd7, 1'b1, 32'h0,        1'b0},
        '{MODE_UNUSED, 3'd5, 32'hFFFFFFFF, 3'd2, 1'b1, 32'h0,        1'b0},
        '{MODE_RECORD, 3'd0, 32'h0,        3'd0, 1'b1, 32'h0,        1'b0},
        '{MODE_RECORD, 3'd7, 32'hFFFFFFFF, 3'd7, 1'b1, 32'h0,        1'b0},
        '{MODE_READ,   3'd0, 32'h0,        3'd7, 1'b1, 32'hFFFFFFFF, 1'b1},
        '{MODE_READ,   3'd7, 32'hFFFFFFFF, 3'd0, 1'b1, 32'hFFFFFFFF, 1'b1},
        '{MODE_READ,   3'd0, 32'h0,        3'd0, 1'b1, 32'h0,        1'b0},
        '{MODE_RECORD, 3'd3, 32'h80000000, 3'd5, 1'b1, 32'h0,        1'b0},
        '{MODE_READ,   3'd3, 32'h0,        3'd0, 1'b1, 32'h80000000, 1'b1},
        '{MODE_READ,   3'd7, 32'h0,        3'd3, 1'b1, 32'h7FFFFFFF, 1'b1},
        '{MODE_RECORD, 3'd0, 32'hFFFFFFFF, 3'd1, 1'b1, 32'h0,        1'b0},
        '{MODE_READ,   3'd0, 32'h0,        3'd7, 1'b1, 32'h0,        1'b1},
        '{MODE_READ,   3'd0, 32'h0,        3'd3, 1'b0, 32'h0,        1'b0},
        '{MODE_RECORD, 3'd5, 32'h12345678, 3'd6, 1'b1, 32'h0,        1'b0},
        '{MODE_READ,   3'd5, 32'h0,        3'd0, 1'b0, 32'h0,        1'b0},
        '{MODE_CLEAR,  3'd7, 32'hFFFFFFFF, 3'd7, 1'b1, 32'h0,        1'b0},
        '{MODE_READ,   3'd0, 32'h0,        3'd7, 1'b1, 32'h0,        1'b0},
        '{MODE_RECORD, 3'd2, 32'd5,        3'd0, 1'b1, 32'h0,        1'b0},
        '{MODE_READ,   3'd2, 32'h0,        3'd0, 1'b1, 32'h0,        1'b0},
        '{MODE_RECORD, 3'd2, 32'd9,        3'd0, 1'b1, 32'h0,        1'b0},
        '{MODE_RECORD, 3'd6, 32'd7,        3'd0, 1'b1, 32'h0,        1'b0},
        '{MODE_READ,   3'd6, 32'h0,        3'd2, 1'b1, 32'd2,        1'b1},
        '{MODE_UNUSED, 3'd2, 32'd9,        3'd6, 1'b1, 32'h0,        1'b0},
        '{MODE_READ,   3'd2, 32'h0,        3'd6, 1'b1, 32'd2,        1'b1}
    };

    initial
    begin
        int sent;
        int phase_target;
        minimum_rsp_t typed;
        clear_tracker();

        // reset once, released at a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows; no idling yet
        foreach (directed_rows[i])
        begin
            typed.distance = directed_rows[i].distance;
            typed.found = directed_rows[i].found;
            send_request(directed_rows[i].mode, directed_rows[i].term,
                         directed_rows[i].position, directed_rows[i].other_term,
                         directed_rows[i].known, typed);
        end

        // three random phases: slow receiver, slow sender, no idling
        sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 85 : 0;
            stall_pct     = (phase == 0) ? 85 : (phase == 1) ? 8 : 0;
            if (phase == 2)
            begin
                // long receiver hold-off while requests keep coming, so the
                // block fills up and pushes back on its input
                hold_asked++;
            end
            phase_target = (RANDOM_REQUESTS * (phase + 1)) / 3;
            while (sent < phase_target)
            begin
                if ($urandom_range(9) < 8)
                    send_document(sent);
                else
                    send_noise(sent);
            end
            // sender pauses until every queued response is back
            @(negedge clk);
            req_valid <= 1'b0;
            drain_responses();
        end

        // settle: catch any stray response after the last expected one
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mpd_pkg.sv
rtl/core/mpd_lower_unit.sv
rtl/core/min_pairwise_term_distance_top.sv
bench/tb_min_pairwise_term_distance_top.sv
